@@ design/tkmd_pkg.sv @@
package tkmd_pkg;

	localparam int LIST_MAX_DEF  = 32;
	localparam int BATCH_MAX_DEF = 32;

	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 2;
	localparam int SCORE_W = 32;
	localparam int ID_W    = 31;
	localparam int RANK_W  = 6;

	localparam logic [FUNC_W-1:0] FUNC_BATCH  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [SCORE_W-1:0] score;
		logic [ID_W-1:0]           entry_id;
		logic [ID_W-1:0]           server_id;
		logic                      batch_end;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [SCORE_W-1:0] out_score;
		logic [ID_W-1:0]           out_entry_id;
		logic [ID_W-1:0]           out_server_id;
		logic [RANK_W-1:0]         rank;
		logic                      found;
		logic [RANK_W-1:0]         entries_left;
		logic                      run_end;
	} res_t;

endpackage

@@ design/tkmd_stream_if.sv @@
interface tkmd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/top_k_merge_dense_rank_table_core.sv @@
// Channel  Dir  Payload  Transfer
// req      in   req_t    req.valid && req.ready
// res      out  res_t    res.valid && res.ready
//
// Batch entry without batch_end: stored if the batch memory has room, no result. Merge: a priming
// read, then min(LIST_MAX, list + batch) emitted entries, one list/batch memory read pair per entry.
// Removal: a priming read, then a walk over every list entry; query: the same walk, ending at
// the first hit or the list's end (one read a cycle); on an empty list either goes straight to its result.
// Reset clears the control state and both counts; the memories keep their contents.
// A stalled res channel holds the merge walk; req is taken only between operations.
module top_k_merge_dense_rank_table_core #(
	parameter int LIST_MAX  = tkmd_pkg::LIST_MAX_DEF,
	parameter int BATCH_MAX = tkmd_pkg::BATCH_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tkmd_stream_if.sink    req,
	tkmd_stream_if.source  res
);
	import tkmd_pkg::*;

	localparam int LIW = $clog2(LIST_MAX);
	localparam int LCW = $clog2(LIST_MAX + 1);
	localparam int BIW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
	localparam int BCW = $clog2(BATCH_MAX + 1);
	localparam int SW  = ((LCW > BCW) ? LCW : BCW) + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PRIME  = 3'd1;
	localparam logic [2:0] S_MERGE  = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [ID_W-1:0]           entry;
		logic [ID_W-1:0]           server;
		logic [RANK_W-1:0]         rank;
	} lent_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [ID_W-1:0]           entry;
		logic [ID_W-1:0]           server;
	} bent_t;

	lent_t list_mem [2][LIST_MAX];
	bent_t batch_mem [BATCH_MAX];
	lent_t lrd_q;
	bent_t brd_q;

	logic [2:0]        state_q;
	logic              bank_q;
	logic [LCW-1:0]    count_q, li_q, n_q, total_q;
	logic [BCW-1:0]    bcount_q, bi_q;
	logic [FUNC_W-1:0] op_q;
	logic [ID_W-1:0]   key_q;
	logic [SCORE_W-1:0] prev_score_q;
	logic [RANK_W-1:0] prev_rank_q;
	logic              out_valid_q;
	res_t              out_q, pend_q;

	logic              in_fire, out_free, take_batch, batch_store, walk_last, keep, hit;
	logic [LCW-1:0]    li_inc, n_inc;
	logic [BCW-1:0]    bi_inc, bcount_nx;
	logic [SW-1:0]     sum;
	logic [LCW-1:0]    total_nx;
	logic [LIW-1:0]    lra;
	logic [BIW-1:0]    bra;
	logic              lwe, bwe;
	lent_t             lwd;
	bent_t             sel;
	logic [RANK_W-1:0] sel_rank, walk_rank;
	res_t              merge_res;

	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign li_inc = li_q + LCW'(1);
	assign n_inc  = n_q + LCW'(1);
	assign bi_inc = bi_q + BCW'(1);

	assign batch_store = (bcount_q < BCW'(BATCH_MAX));
	assign bcount_nx   = batch_store ? bcount_q + BCW'(1) : bcount_q;
	assign sum         = SW'(count_q) + SW'(bcount_nx);
	assign total_nx    = (sum > SW'(LIST_MAX)) ? LCW'(LIST_MAX) : LCW'(sum);

	assign take_batch = (li_q >= count_q) ||
		((bi_q < bcount_q) && ($signed(brd_q.score) > $signed(lrd_q.score)));

	always_comb begin
		if (take_batch) begin
			sel = brd_q;
		end else begin
			sel = '{score: lrd_q.score, entry: lrd_q.entry, server: lrd_q.server};
		end
	end

	assign sel_rank  = (n_q == '0) ? RANK_W'(1) :
		((sel.score == prev_score_q) ? prev_rank_q : prev_rank_q + RANK_W'(1));
	assign walk_rank = (n_q == '0) ? RANK_W'(1) :
		((lrd_q.score == prev_score_q) ? prev_rank_q : prev_rank_q + RANK_W'(1));

	assign walk_last = (li_inc == count_q);
	assign keep      = (lrd_q.server != key_q);
	assign hit       = (lrd_q.entry == key_q);

	always_comb begin
		merge_res               = '0;
		merge_res.kind          = KIND_ENTRY;
		merge_res.out_score     = sel.score;
		merge_res.out_entry_id  = sel.entry;
		merge_res.out_server_id = sel.server;
		merge_res.rank          = sel_rank;
		merge_res.entries_left  = RANK_W'(total_q);
		merge_res.run_end       = (n_inc == total_q);
	end

	always_comb begin
		lra = li_q[LIW-1:0];
		bra = bi_q[BIW-1:0];
		lwe = 1'b0;
		lwd = '{score: sel.score, entry: sel.entry, server: sel.server, rank: sel_rank};
		unique case (state_q)
			S_PRIME: begin
				lra = '0;
				bra = '0;
			end
			S_MERGE: begin
				if (out_free) begin
					lwe = 1'b1;
					if (take_batch) begin
						bra = bi_inc[BIW-1:0];
					end else begin
						lra = li_inc[LIW-1:0];
					end
				end
			end
			S_WALK: begin
				lra = li_inc[LIW-1:0];
				lwe = (op_q == FUNC_REMOVE) && keep;
				lwd = '{score: lrd_q.score, entry: lrd_q.entry, server: lrd_q.server,
					rank: walk_rank};
			end
			default: begin
			end
		endcase
	end

	assign bwe = in_fire && (req.data.func == FUNC_BATCH) && batch_store;

	always_ff @(posedge clk) begin
		if (lwe) begin
			list_mem[~bank_q][n_q[LIW-1:0]] <= lwd;
		end
		lrd_q <= list_mem[bank_q][lra];
		if (bwe) begin
			batch_mem[bcount_q[BIW-1:0]] <= '{score: req.data.score,
				entry: req.data.entry_id, server: req.data.server_id};
		end
		brd_q <= batch_mem[bra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bank_q   <= 1'b0;
			count_q  <= '0;
			bcount_q <= '0;
			li_q     <= '0;
			bi_q     <= '0;
			n_q      <= '0;
			total_q  <= '0;
			op_q     <= FUNC_BATCH;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						li_q <= '0;
						bi_q <= '0;
						n_q  <= '0;
						op_q <= req.data.func;
						unique case (req.data.func)
							FUNC_BATCH: begin
								bcount_q <= bcount_nx;
								if (req.data.batch_end) begin
									total_q <= total_nx;
									state_q <= S_PRIME;
								end
							end
							FUNC_REMOVE, FUNC_QUERY: begin
								state_q <= (count_q == '0) ? S_RESULT : S_PRIME;
							end
							default: begin
							end
						endcase
					end
				end
				S_PRIME: begin
					state_q <= (op_q == FUNC_BATCH) ? S_MERGE : S_WALK;
				end
				S_MERGE: begin
					if (out_free) begin
						n_q <= n_inc;
						if (take_batch) begin
							bi_q <= bi_inc;
						end else begin
							li_q <= li_inc;
						end
						if (n_inc == total_q) begin
							count_q  <= total_q;
							bcount_q <= '0;
							bank_q   <= ~bank_q;
							state_q  <= S_IDLE;
						end
					end
				end
				S_WALK: begin
					li_q <= li_inc;
					if (op_q == FUNC_REMOVE) begin
						if (keep) begin
							n_q <= n_inc;
						end
						if (walk_last) begin
							count_q <= keep ? n_inc : n_q;
							bank_q  <= ~bank_q;
							state_q <= S_RESULT;
						end
					end else if (hit || walk_last) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MERGE && out_free) begin
			prev_score_q <= sel.score;
			prev_rank_q  <= sel_rank;
		end else if (state_q == S_WALK && keep) begin
			prev_score_q <= lrd_q.score;
			prev_rank_q  <= walk_rank;
		end

		if (in_fire) begin
			key_q  <= (req.data.func == FUNC_REMOVE) ?
				req.data.server_id : req.data.entry_id;
			pend_q <= '{kind: (req.data.func == FUNC_REMOVE) ? KIND_REMOVED : KIND_QUERY,
				out_score: '0,
				out_entry_id: (req.data.func == FUNC_REMOVE) ? ID_W'(0) : req.data.entry_id,
				out_server_id: '0, rank: '0, found: 1'b0, entries_left: '0, run_end: 1'b1};
		end else if (state_q == S_WALK) begin
			if (op_q == FUNC_REMOVE) begin
				pend_q.entries_left <= RANK_W'(keep ? n_inc : n_q);
			end else if (hit) begin
				pend_q.found <= 1'b1;
				pend_q.rank  <= lrd_q.rank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_MERGE || state_q == S_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MERGE && out_free) begin
			out_q <= merge_res;
		end else if (state_q == S_RESULT && out_free) begin
			out_q <= pend_q;
		end
	end

endmodule

@@ sim/tb_top_k_merge_dense_rank_table_core.sv @@
`timescale 1ns / 100ps

module tb_top_k_merge_dense_rank_table_core;
	import tkmd_pkg::*;

	localparam int LIST_MAX  = LIST_MAX_DEF;
	localparam int BATCH_MAX = BATCH_MAX_DEF;
	localparam int LIMIT     = 500000;
	localparam int HOLD_LEN  = 300;
	localparam int TAIL      = 40;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

	typedef struct {
		req_t item;
		bit   drain;
	} plan_t;

	logic clk;
	logic arst_n;

	tkmd_stream_if #(.payload_t(req_t)) req_if ();
	tkmd_stream_if #(.payload_t(res_t)) res_if ();

	top_k_merge_dense_rank_table_core #(
		.LIST_MAX(LIST_MAX),
		.BATCH_MAX(BATCH_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if)
	);

	logic signed [SCORE_W-1:0] board_score [LIST_MAX];
	logic [ID_W-1:0]           board_entry [LIST_MAX];
	logic [ID_W-1:0]           board_server [LIST_MAX];
	logic [RANK_W-1:0]         board_rank [LIST_MAX];
	int                        board_len;
	logic signed [SCORE_W-1:0] pend_score [BATCH_MAX];
	logic [ID_W-1:0]           pend_entry [BATCH_MAX];
	logic [ID_W-1:0]           pend_server [BATCH_MAX];
	int                        pend_len;

	plan_t req_plan [$];
	res_t  due_rows [$];
	res_t  got, want;
	logic  req_xfer;

	int n_taken, n_rows, n_fail, n_cycles;
	int n_merges, n_removals, n_queries, n_hits, n_dropped, n_ignored, longest;

	function automatic res_t make_row(logic [KIND_W-1:0] kind, logic signed [SCORE_W-1:0] sc,
		logic [ID_W-1:0] id, logic [ID_W-1:0] srv, logic [RANK_W-1:0] rk, logic fd,
		logic [RANK_W-1:0] left, logic last);
		res_t r;
		r.kind          = kind;
		r.out_score     = sc;
		r.out_entry_id  = id;
		r.out_server_id = srv;
		r.rank          = rk;
		r.found         = fd;
		r.entries_left  = left;
		r.run_end       = last;
		return r;
	endfunction

	function automatic string row_text(res_t r);
		return $sformatf("kind=%0d score=%0d entry=%0d server=%0d rank=%0d found=%0d left=%0d last=%0d",
			r.kind, r.out_score, r.out_entry_id, r.out_server_id, r.rank, r.found,
			r.entries_left, r.run_end);
	endfunction

	task automatic rerank_board();
		for (int i = 0; i < board_len; i++) begin
			if (i == 0)
				board_rank[i] = RANK_W'(1);
			else if (board_score[i] == board_score[i-1])
				board_rank[i] = board_rank[i-1];
			else
				board_rank[i] = board_rank[i-1] + 1'b1;
		end
	endtask

	task automatic track_board(input req_t r);
		logic signed [SCORE_W-1:0] ns [LIST_MAX];
		logic [ID_W-1:0]           ne [LIST_MAX];
		logic [ID_W-1:0]           nv [LIST_MAX];
		int  li, bi, n, hit;
		bit  take;
		case (r.func)
		FUNC_BATCH: begin
			if (pend_len < BATCH_MAX) begin
				pend_score[pend_len]  = r.score;
				pend_entry[pend_len]  = r.entry_id;
				pend_server[pend_len] = r.server_id;
				pend_len++;
			end else begin
				n_dropped++;
			end
			if (r.batch_end) begin
				li = 0;
				bi = 0;
				n  = 0;
				while (n < LIST_MAX && (li < board_len || bi < pend_len)) begin
					if (li >= board_len)
						take = 1'b1;
					else if (bi >= pend_len)
						take = 1'b0;
					else
						take = pend_score[bi] > board_score[li];
					if (take) begin
						ns[n] = pend_score[bi];
						ne[n] = pend_entry[bi];
						nv[n] = pend_server[bi];
						bi++;
					end else begin
						ns[n] = board_score[li];
						ne[n] = board_entry[li];
						nv[n] = board_server[li];
						li++;
					end
					n++;
				end
				for (int i = 0; i < n; i++) begin
					board_score[i]  = ns[i];
					board_entry[i]  = ne[i];
					board_server[i] = nv[i];
				end
				board_len = n;
				pend_len  = 0;
				rerank_board();
				n_merges++;
				if (board_len > longest)
					longest = board_len;
				for (int i = 0; i < board_len; i++)
					due_rows = {due_rows, make_row(KIND_ENTRY, board_score[i], board_entry[i],
						board_server[i], board_rank[i], 1'b0, RANK_W'(board_len),
						i == board_len - 1)};
			end
		end
		FUNC_REMOVE: begin
			n = 0;
			for (int i = 0; i < board_len; i++) begin
				if (board_server[i] != r.server_id) begin
					board_score[n]  = board_score[i];
					board_entry[n]  = board_entry[i];
					board_server[n] = board_server[i];
					n++;
				end
			end
			board_len = n;
			rerank_board();
			n_removals++;
			due_rows = {due_rows, make_row(KIND_REMOVED, '0, '0, '0, '0, 1'b0,
				RANK_W'(board_len), 1'b1)};
		end
		FUNC_QUERY: begin
			hit = -1;
			for (int i = 0; i < board_len; i++)
				if (hit < 0 && board_entry[i] == r.entry_id)
					hit = i;
			n_queries++;
			if (hit >= 0) begin
				n_hits++;
				due_rows = {due_rows, make_row(KIND_QUERY, '0, r.entry_id, '0, board_rank[hit],
					1'b1, '0, 1'b1)};
			end else begin
				due_rows = {due_rows, make_row(KIND_QUERY, '0, r.entry_id, '0, '0, 1'b0, '0,
					1'b1)};
			end
		end
		default: begin
			n_ignored++;
		end
		endcase
	endtask

	task automatic plan_item(input logic [FUNC_W-1:0] f, input logic signed [SCORE_W-1:0] sc,
		input logic [ID_W-1:0] id, input logic [ID_W-1:0] srv, input logic last,
		input bit drain);
		plan_t p;
		p.item.func      = f;
		p.item.score     = sc;
		p.item.entry_id  = id;
		p.item.server_id = srv;
		p.item.batch_end = last;
		p.drain          = drain;
		req_plan = {req_plan, p};
	endtask

	function automatic logic [ID_W-1:0] pick_key(int pool);
		if ($urandom_range(0, 3) == 0)
			return ID_W'($urandom);
		return ID_W'($urandom_range(0, pool - 1));
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: check results first, then account for the accepted request
	always @(posedge clk) begin
		req_xfer <= arst_n && req_if.valid && req_if.ready;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (due_rows.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected result: %s", row_text(got));
			end else begin
				want = due_rows.pop_front();
				n_rows++;
				if (got.kind !== want.kind || got.out_score !== want.out_score ||
					got.out_entry_id !== want.out_entry_id ||
					got.out_server_id !== want.out_server_id || got.rank !== want.rank ||
					got.found !== want.found || got.entries_left !== want.entries_left ||
					got.run_end !== want.run_end) begin
					n_fail++;
					if (n_fail <= 10) begin
						$display("mismatch at row %0d expected: %s", n_rows, row_text(want));
						$display("mismatch at row %0d actual:   %s", n_rows, row_text(got));
					end
				end
			end
		end
		if (arst_n && req_if.valid && req_if.ready) begin
			n_taken++;
			track_board(req_if.data);
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d rows outstanding", n_cycles, due_rows.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	int    burst_left;
	int    gap_left;
	plan_t next_up;

	// driver: bursts of transfers with random gaps; a drain item waits until no rows are due
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_xfer) begin
			if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (req_plan.size() == 0 || (req_plan[0].drain && due_rows.size() != 0)) begin
				req_if.valid <= 1'b0;
			end else begin
				next_up = req_plan.pop_front();
				req_if.data  <= next_up.item;
				req_if.valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
	end

	int          hold_left;
	int          holds_done;
	int          mode_left;
	ready_mode_t ready_mode;
	logic [7:0]  ready_pat;

	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else if (res_if.valid && ((holds_done == 0 && n_rows >= 30) ||
			(holds_done == 1 && n_rows >= 600))) begin
			hold_left = HOLD_LEN - 1;
			holds_done++;
			res_if.ready <= 1'b0;
		end else begin
			if (mode_left <= 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(16, 128);
				ready_pat  = 8'($urandom) | 8'h01;
			end
			mode_left--;
			ready_pat = {ready_pat[6:0], ready_pat[7]};
			case (ready_mode)
			RDY_ALWAYS: res_if.ready <= 1'b1;
			RDY_COIN: res_if.ready <= 1'($urandom_range(0, 1));
			RDY_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
			default: res_if.ready <= ready_pat[0];
			endcase
		end
	end

	initial begin
		int n_items;
		int pick;
		int len;
		int seq_no;
		int val;
		int scores [$];
		bit narrow;
		bit leave_open;
		bit drain;
		bit big_done;
		arst_n = 1'b0;

		plan_item(FUNC_QUERY, '0, 31'd5, '0, 1'b0, 1'b0);
		plan_item(FUNC_REMOVE, '0, '0, 31'd3, 1'b0, 1'b0);
		plan_item(FUNC_UNUSED, 32'sd9, 31'd9, 31'd9, 1'b1, 1'b0);
		plan_item(FUNC_BATCH, 32'sh7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 1'b0);
		plan_item(FUNC_BATCH, 32'sd100, 31'd1, 31'd1, 1'b0, 1'b0);
		plan_item(FUNC_BATCH, 32'sd100, 31'd2, 31'd2, 1'b0, 1'b0);
		plan_item(FUNC_BATCH, 32'sh80000000, 31'd0, 31'd0, 1'b1, 1'b0);
		plan_item(FUNC_BATCH, 32'sd100, 31'd3, 31'd3, 1'b1, 1'b0);
		plan_item(FUNC_BATCH, -32'sd5, 31'd4, 31'd4, 1'b0, 1'b0);
		plan_item(FUNC_BATCH, 32'sd50, 31'd5, 31'd5, 1'b1, 1'b0);
		plan_item(FUNC_BATCH, 32'sd7, 31'd9, 31'd9, 1'b0, 1'b0);
		plan_item(FUNC_QUERY, '0, 31'd2, '0, 1'b1, 1'b0);
		plan_item(FUNC_REMOVE, '0, '0, 31'd1, 1'b1, 1'b0);
		plan_item(FUNC_QUERY, '0, 31'd1, '0, 1'b0, 1'b0);
		plan_item(FUNC_REMOVE, '0, '0, 31'd77, 1'b0, 1'b0);
		plan_item(FUNC_BATCH, 32'sd7, 31'd2, 31'd9, 1'b1, 1'b0);
		plan_item(FUNC_QUERY, '0, 31'd2, '0, 1'b0, 1'b0);
		plan_item(FUNC_QUERY, '0, 31'h7FFFFFFF, '0, 1'b0, 1'b0);
		plan_item(FUNC_REMOVE, '0, '0, 31'd9, 1'b0, 1'b1);
		plan_item(FUNC_REMOVE, '0, '0, 31'h7FFFFFFF, 1'b0, 1'b0);

		seq_no   = 0;
		big_done = 0;
		while (req_plan.size() < 330) begin
			pick  = $urandom_range(0, 99);
			drain = (seq_no % 16 == 5);
			seq_no++;
			if (pick < 58) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				if (!big_done && req_plan.size() > 150) begin
					len      = BATCH_MAX + 3;
					big_done = 1;
				end
				narrow = ($urandom_range(0, 2) == 0);
				scores.delete();
				for (int k = 0; k < len; k++) begin
					if (narrow)
						val = int'($urandom_range(0, 6)) - 3;
					else if ($urandom_range(0, 15) == 0)
						val = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
					else
						val = $urandom;
					scores = {scores, val};
				end
				if ($urandom_range(0, 9) != 0)
					scores.rsort();
				leave_open = ($urandom_range(0, 19) == 0);
				for (int k = 0; k < len; k++)
					plan_item(FUNC_BATCH, scores[k], pick_key(16), pick_key(8),
						k == len - 1 && !leave_open, drain && k == 0);
			end else if (pick < 70) begin
				plan_item(FUNC_REMOVE, $urandom, pick_key(16), pick_key(8),
					1'($urandom_range(0, 1)), drain);
			end else if (pick < 96) begin
				plan_item(FUNC_QUERY, $urandom, pick_key(16), pick_key(8),
					1'($urandom_range(0, 1)), drain);
			end else begin
				plan_item(FUNC_UNUSED, $urandom, pick_key(16), pick_key(8),
					1'($urandom_range(0, 1)), drain);
			end
		end
		n_items = req_plan.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_items || due_rows.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);

		$display("%0d requests: %0d merges, %0d removals, %0d queries (%0d hits), %0d ignored",
			n_taken, n_merges, n_removals, n_queries, n_hits, n_ignored);
		$display("%0d rows checked, longest board %0d, %0d batch entries dropped, %0d failures",
			n_rows, longest, n_dropped, n_fail);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
